// ===== hdl/isqf_pkg.sv =====
`timescale 1ns / 1ps
package isqf_pkg;

  // Field widths of the input and result words
  localparam int unsigned RADICAND_W  = 31;
  localparam int unsigned INT_ROOT_W  = 16;
  localparam int unsigned SCALED_W    = 33;

  // Integer root search works on the radicand zero-extended to an even width
  localparam int unsigned INT_RAD_W   = 2 * INT_ROOT_W;

  // Decimal scale 10^(2*digits) fits this width for up to five digits
  localparam int unsigned SCALE_MAX_W = 34;
  // The scale multiply is cut into two halves of this width
  localparam int unsigned SPLIT_W     = 17;
  localparam int unsigned PROD_W      = RADICAND_W + SPLIT_W;

  // Power of ten, evaluated at elaboration only
  function automatic logic [63:0] pow10(input int unsigned e);
    logic [63:0] r;
    r = 64'd1;
    for (int unsigned i = 0; i < e; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

// ===== hdl/isqf_if.sv =====
`timescale 1ns / 1ps
// Radicand channel
interface isqf_in_if;
  import isqf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [RADICAND_W-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

// Root channel
interface isqf_out_if;
  import isqf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INT_ROOT_W-1:0] int_root;
  logic [SCALED_W-1:0]   scaled_root;

  modport source (output valid, output int_root, output scaled_root, input ready);
  modport sink   (input valid, input int_root, input scaled_root, output ready);
endinterface

// ===== hdl/integer_square_root_with_fraction.sv =====
`timescale 1ns / 1ps
// Stages: one scale-multiply stage, one add stage, then one restoring root stage per bit
// of the scaled root, whose width is QW; the last stage drives the output.
// Throughput: one word per cycle; a stage stalls only when it and every stage after it
// are full and the output is stalled. Reset: asynchronous, clears the stage valid bits.
module integer_square_root_with_fraction #(
  parameter int unsigned FRAC_DIGITS = 5
) (
  input logic        clk_i,
  input logic        rst_ni,
  isqf_in_if.sink    in_i,
  isqf_out_if.source out_o
);
  import isqf_pkg::*;

  // floor(sqrt(n) * 10^d) == floor(sqrt(n * 10^(2d)))
  localparam logic [SCALE_MAX_W-1:0] SCALE    = SCALE_MAX_W'(pow10(2 * FRAC_DIGITS));
  localparam int unsigned            SCALE_W  = $clog2(SCALE + 1);
  localparam int unsigned            RW       = RADICAND_W + SCALE_W;
  localparam int unsigned            QW       = (RW + 1) / 2;
  localparam int unsigned            NST      = QW + 2;
  localparam logic [SPLIT_W-1:0]     SCALE_LO = SCALE[SPLIT_W-1:0];
  localparam logic [SPLIT_W-1:0]     SCALE_HI = SPLIT_W'(SCALE >> SPLIT_W);

  // Stage valid bits and per-stage load enables
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  // Multiply and add stages
  logic [RADICAND_W-1:0]       n0_q, n1_q;
  logic [PROD_W-1:0]           plo_q, phi_q;
  logic [PROD_W+SPLIT_W-1:0]   sum_w;
  logic [2*QW-1:0]             rad1_d, rad1_q;

  // Root stages
  logic [2*QW-1:0]       rad_q   [QW];
  logic [QW+1:0]         rem_q   [QW];
  logic [QW-1:0]         root_q  [QW];
  logic [INT_RAD_W-1:0]  irad_q  [QW];
  logic [INT_ROOT_W+1:0] irem_q  [QW];
  logic [INT_ROOT_W-1:0] iroot_q [QW];

  // A stage loads when it is empty or the stage after it moves
  assign en[NST-1] = ~v_q[NST-1] | out_o.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int unsigned k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Scale multiply, split in two 31x17 partial products
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      n0_q  <= in_i.radicand;
      plo_q <= PROD_W'(in_i.radicand) * PROD_W'(SCALE_LO);
      phi_q <= PROD_W'(in_i.radicand) * PROD_W'(SCALE_HI);
    end
  end

  // Recombine partial products into the scaled radicand
  assign sum_w = (PROD_W + SPLIT_W)'(plo_q) + {phi_q, {SPLIT_W{1'b0}}};

  always_comb begin
    rad1_d         = '0;
    rad1_d[RW-1:0] = sum_w[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      n1_q   <= n0_q;
      rad1_q <= rad1_d;
    end
  end

  // One restoring root bit per stage; the integer root runs alongside in the first stages
  for (genvar j = 0; j < QW; j++) begin : g_root
    logic [2*QW-1:0]       rad_in, rad_d;
    logic [QW+1:0]         rem_in, rem_d, cand, trial;
    logic [QW-1:0]         root_in, root_d;
    logic [INT_RAD_W-1:0]  irad_in, irad_d;
    logic [INT_ROOT_W+1:0] irem_in, irem_d;
    logic [INT_ROOT_W-1:0] iroot_in, iroot_d;
    logic                  ge;

    if (j == 0) begin : g_first
      assign rad_in   = rad1_q;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign irad_in  = INT_RAD_W'(n1_q);
      assign irem_in  = '0;
      assign iroot_in = '0;
    end else begin : g_next
      assign rad_in   = rad_q[j-1];
      assign rem_in   = rem_q[j-1];
      assign root_in  = root_q[j-1];
      assign irad_in  = irad_q[j-1];
      assign irem_in  = irem_q[j-1];
      assign iroot_in = iroot_q[j-1];
    end

    // Scaled root bit
    assign cand   = {rem_in[QW-1:0], rad_in[2*QW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (cand >= trial);
    assign rem_d  = ge ? (cand - trial) : cand;
    assign root_d = {root_in[QW-2:0], ge};
    assign rad_d  = rad_in << 2;

    // Integer root bit
    if (j < INT_ROOT_W) begin : g_int
      logic [INT_ROOT_W+1:0] icand, itrial;
      logic                  ige;
      assign icand   = {irem_in[INT_ROOT_W-1:0], irad_in[INT_RAD_W-1 -: 2]};
      assign itrial  = {iroot_in, 2'b01};
      assign ige     = (icand >= itrial);
      assign irem_d  = ige ? (icand - itrial) : icand;
      assign iroot_d = {iroot_in[INT_ROOT_W-2:0], ige};
      assign irad_d  = irad_in << 2;
    end else begin : g_hold
      assign irem_d  = irem_in;
      assign iroot_d = iroot_in;
      assign irad_d  = irad_in;
    end

    always_ff @(posedge clk_i) begin
      if (en[j+2]) begin
        rad_q[j]   <= rad_d;
        rem_q[j]   <= rem_d;
        root_q[j]  <= root_d;
        irad_q[j]  <= irad_d;
        irem_q[j]  <= irem_d;
        iroot_q[j] <= iroot_d;
      end
    end
  end

  // Result word from the last stage
  assign out_o.valid    = v_q[NST-1];
  assign out_o.int_root = iroot_q[QW-1];

  always_comb begin
    out_o.scaled_root         = '0;
    out_o.scaled_root[QW-1:0] = root_q[QW-1];
  end

endmodule

// ===== hdl/isqf_checker.sv =====
`timescale 1ns / 1ps
module isqf_checker #(
  parameter int unsigned FRAC_DIGITS = 5
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [isqf_pkg::INT_ROOT_W-1:0] int_root_i,
  input logic [isqf_pkg::SCALED_W-1:0]   scaled_root_i
);
  import isqf_pkg::*;

  localparam logic [63:0] SCALE = pow10(FRAC_DIGITS);

  // Result word is held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(int_root_i)
      && $stable(scaled_root_i))
    else $error("result word changed while stalled");

  // Pipeline refuses input only when full and blocked at the output
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // Scaled root lies within one integer step of the integer root
  a_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (64'(int_root_i) * SCALE <= 64'(scaled_root_i))
      && (64'(scaled_root_i) < (64'(int_root_i) + 64'd1) * SCALE))
    else $error("scaled root disagrees with integer root");

  // No result during reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // Nothing comes out in the cycle right after reset release
  a_reset_exit: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind integer_square_root_with_fraction isqf_checker #(
  .FRAC_DIGITS(FRAC_DIGITS)
) u_isqf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .int_root_i    (out_o.int_root),
  .scaled_root_i (out_o.scaled_root)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import isqf_pkg::*;

  localparam int unsigned FRAC_DIGITS  = 5;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [RADICAND_W-1:0] RAD_MAX = {RADICAND_W{1'b1}};

  // One expected result word, kept with the radicand that caused it
  typedef struct {
    logic [RADICAND_W-1:0] radicand;
    logic [INT_ROOT_W-1:0] int_root;
    logic [SCALED_W-1:0]   scaled_root;
  } root_word_t;

  logic clk_i;
  logic rst_ni;

  isqf_in_if  in_if ();
  isqf_out_if out_if ();

  integer_square_root_with_fraction #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [RADICAND_W-1:0] radicand_q[$];
  root_word_t            root_expect_q[$];
  int unsigned           words_total;
  int unsigned           words_taken;
  int unsigned           error_count;
  int unsigned           idle_cycles;
  int unsigned           send_gap;
  int unsigned           recv_gap;
  bit                    send_calm;
  bit                    recv_calm;

  // floor(sqrt(v)), one result bit per step from the top
  function automatic logic [63:0] floor_sqrt(logic [127:0] v, int unsigned bits);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int b = int'(bits) - 1; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[63:0];
  endfunction

  // Integer root and root * 10^digits: the latter is floor(sqrt(n * 10^(2*digits)))
  function automatic root_word_t predict_roots(logic [RADICAND_W-1:0] rad);
    root_word_t   w;
    logic [127:0] scale;
    logic [63:0]  ir;
    logic [63:0]  sr;
    scale = 128'd1;
    for (int i = 0; i < 2 * FRAC_DIGITS; i++) scale = scale * 128'd10;
    ir = floor_sqrt(128'(rad), INT_ROOT_W);
    sr = floor_sqrt(128'(rad) * scale, SCALED_W + 1);
    w.radicand    = rad;
    w.int_root    = ir[INT_ROOT_W-1:0];
    w.scaled_root = sr[SCALED_W-1:0];
    return w;
  endfunction

  // Mostly short gaps, a few long ones; none in a calm stretch
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [RADICAND_W-1:0] rad,
                                 logic [63:0] want, logic [63:0] got);
    error_count++;
    $display("%0t mismatch %s: radicand %0d expected %0d got %0d",
             $realtime, what, rad, want, got);
  endtask

  // Random radicand, weighted toward squares, their neighbors and the ends
  function automatic logic [RADICAND_W-1:0] pick_radicand();
    longint unsigned k;
    longint unsigned v;
    int unsigned     sh;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom();
      3:       v = $urandom_range(0, 1000);
      4, 5: begin
        k = $urandom_range(1, 46340);
        case ($urandom_range(0, 3))
          0:       v = k * k - 1;
          1:       v = k * k;
          2:       v = k * k + 1;
          default: v = k * k + 2 * k;
        endcase
        if (v > RAD_MAX) v = RAD_MAX;
      end
      6, 7: begin
        sh = $urandom_range(0, 31);
        v = $urandom() >> sh;
      end
      8: v = RAD_MAX - $urandom_range(0, 100000);
      default: begin
        sh = $urandom_range(0, RADICAND_W - 1);
        v = $urandom_range(0, 1) ? (64'd1 << sh) : ((64'd1 << sh) - 1);
      end
    endcase
    return v[RADICAND_W-1:0];
  endfunction

  // Clock and reset; reset falls just after time zero so its edge is always seen
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b1;
    in_if.valid = 1'b0;
    in_if.radicand = '0;
    out_if.ready = 1'b0;
    fork
      forever #5 clk_i = ~clk_i;
      begin
        #1 rst_ni = 1'b0;
        repeat (3) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  // Stimulus and end of run
  initial begin
    words_taken = 0;
    error_count = 0;
    send_gap = 0;
    recv_gap = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    // Zero, one, small values, exact squares and their neighbors, the top of the range
    radicand_q = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd8, 31'd15, 31'd16, 31'd17,
                   31'd99, 31'd100, 31'd1000000, 31'd2147395599, 31'd2147395600,
                   31'd2147395601, RAD_MAX, 31'h4000_0000, 31'h3FFF_FFFF,
                   31'h5555_5555, 31'h2AAA_AAAA, 31'd65535, 31'd65536};
    for (int i = 0; i < RANDOM_WORDS; i++) radicand_q.push_back(pick_radicand());
    words_total = radicand_q.size();

    while (words_taken < words_total || root_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (root_expect_q.size() != 0) begin
      report_mismatch("missing root word", root_expect_q[0].radicand, 64'd0, 64'd0);
      void'(root_expect_q.pop_front());
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Radicand driver
  always @(posedge clk_i) begin
    logic next_valid;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      next_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        root_expect_q.push_back(predict_roots(in_if.radicand));
        words_taken++;
        next_valid = 1'b0;
        send_gap = pick_gap(send_calm);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (radicand_q.size() != 0) begin
          in_if.radicand <= radicand_q.pop_front();
          next_valid = 1'b1;
        end
      end
      in_if.valid <= next_valid;
    end
  end

  // Root monitor and back-pressure
  always @(posedge clk_i) begin
    root_word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (root_expect_q.size() == 0) begin
          report_mismatch("unexpected root word", '0, 64'd0, 64'(out_if.int_root));
        end else begin
          want = root_expect_q.pop_front();
          if (out_if.int_root !== want.int_root)
            report_mismatch("int_root", want.radicand, 64'(want.int_root),
                            64'(out_if.int_root));
          if (out_if.scaled_root !== want.scaled_root)
            report_mismatch("scaled_root", want.radicand, 64'(want.scaled_root),
                            64'(out_if.scaled_root));
        end
        recv_gap = pick_gap(recv_calm);
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      end
      out_if.ready <= (recv_gap == 0);
      if (recv_gap != 0) recv_gap--;
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
hdl/isqf_pkg.sv
hdl/isqf_if.sv
hdl/integer_square_root_with_fraction.sv
hdl/isqf_checker.sv
tb/testbench.sv
